// File: rtl/blsb_pkg.sv
// shared types and constants of the bounded lifo stack
`timescale 1ns / 1ps
package blsb_pkg;

  localparam int DEPTH_DEFAULT  = 32;
  localparam int WIDTH_DEFAULT  = 32;
  localparam int CNT_W          = 6;
  localparam int DATA_W         = 32;
  localparam logic [CNT_W-1:0] CAPACITY_RESET = 6'd20;

  typedef enum logic [1:0] {
    ACT_PUSH = 2'd0,
    ACT_POP  = 2'd1,
    ACT_PEEK = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

  // load request from the control into the output register
  typedef struct packed {
    logic             load;
    status_t          status;
    logic             from_ram;
    logic [CNT_W-1:0] occupancy;
    logic             is_empty;
    logic             last;
  } res_t;

endpackage

// File: rtl/blsb_ram.sv
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps
module blsb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/blsb_ctrl.sv
// stack control: fill level, burst tracking, ram addressing and result sequencing
`timescale 1ns / 1ps
module blsb_ctrl #(
  parameter int DEPTH = blsb_pkg::DEPTH_DEFAULT,
  parameter int WIDTH = blsb_pkg::WIDTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wen,
  input  logic [blsb_pkg::CNT_W-1:0]      cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  blsb_pkg::action_t               action,
  input  logic [blsb_pkg::CNT_W-1:0]      count,
  input  logic [blsb_pkg::DATA_W-1:0]     data,
  input  logic                            out_free,
  output blsb_pkg::res_t                  res,
  output logic                            ram_we,
  output logic [$clog2(DEPTH)-1:0]        ram_waddr,
  output logic [WIDTH-1:0]                ram_wdata,
  output logic                            ram_re,
  output logic [$clog2(DEPTH)-1:0]        ram_raddr
);

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int SUM_W  = ((FILL_W > blsb_pkg::CNT_W) ? FILL_W : blsb_pkg::CNT_W) + 1;

  typedef enum logic {
    S_IDLE,
    S_BURST
  } state_t;

  state_t                     state;
  logic [FILL_W-1:0]          fill;
  logic [blsb_pkg::CNT_W-1:0] burst_left;
  logic                       burst_rej;
  logic [blsb_pkg::CNT_W-1:0] capacity;
  logic [blsb_pkg::CNT_W-1:0] remaining;
  logic [ADDR_W-1:0]          rd_addr;
  logic                       pending;
  logic                       pend_last;

  logic                       acc;
  logic [SUM_W-1:0]           eff_cap;
  logic [blsb_pkg::CNT_W-1:0] n;
  logic                       new_burst;
  logic                       rej;
  logic                       push_ok;
  logic [FILL_W-1:0]          fill_inc;
  logic [SUM_W-1:0]           base;
  logic                       underflow;
  logic                       cnt_zero;
  logic [FILL_W-1:0]          fill_after;
  logic                       load_burst;
  logic                       issue;

  assign in_ready  = (state == S_IDLE) && out_free;
  assign acc       = in_valid && in_ready;

  assign eff_cap   = (SUM_W'(capacity) > SUM_W'(DEPTH)) ? SUM_W'(DEPTH) : SUM_W'(capacity);
  assign cnt_zero  = (count == '0);
  assign n         = cnt_zero ? blsb_pkg::CNT_W'(1) : count;
  assign new_burst = (burst_left == '0);
  assign rej       = new_burst ? ((SUM_W'(fill) + SUM_W'(n)) > eff_cap) : burst_rej;
  assign push_ok   = !rej && (fill < FILL_W'(DEPTH));
  assign fill_inc  = FILL_W'(fill + 1'b1);
  assign underflow = SUM_W'(count) > SUM_W'(fill);
  assign base      = SUM_W'(fill) - SUM_W'(count);

  // burst reads: rdata holds while a fetched element waits for the output register
  assign load_burst = (state == S_BURST) && pending && out_free;
  assign issue      = (state == S_BURST) && (remaining != '0) && (!pending || out_free);

  assign ram_we    = acc && (action == blsb_pkg::ACT_PUSH) && push_ok;
  assign ram_waddr = fill[ADDR_W-1:0];
  assign ram_wdata = WIDTH'(data);
  assign ram_re    = issue;
  assign ram_raddr = rd_addr;

  always_comb begin
    res        = '0;
    fill_after = fill;
    if (state == S_BURST) begin
      res.load      = load_burst;
      res.status    = blsb_pkg::ST_OK;
      res.from_ram  = 1'b1;
      res.occupancy = blsb_pkg::CNT_W'(fill);
      res.is_empty  = (fill == '0);
      res.last      = pend_last;
    end else begin
      res.last = 1'b1;
      unique case (action)
        blsb_pkg::ACT_PUSH: begin
          res.load   = acc;
          res.status = push_ok ? blsb_pkg::ST_OK : blsb_pkg::ST_OVERFLOW;
          if (push_ok) begin
            fill_after = fill_inc;
          end
        end
        blsb_pkg::ACT_POP, blsb_pkg::ACT_PEEK: begin
          res.load = acc && (cnt_zero || underflow);
          if (underflow) begin
            res.status = blsb_pkg::ST_UNDERFLOW;
          end else if (action == blsb_pkg::ACT_POP) begin
            fill_after = FILL_W'(base);
          end
        end
        blsb_pkg::ACT_NONE: begin
          res.load = 1'b0;
        end
        default: begin
          res.load = 1'b0;
        end
      endcase
      res.occupancy = blsb_pkg::CNT_W'(fill_after);
      res.is_empty  = (fill_after == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill       <= '0;
      burst_left <= '0;
      burst_rej  <= 1'b0;
      capacity   <= blsb_pkg::CAPACITY_RESET;
      remaining  <= '0;
      pending    <= 1'b0;
      pend_last  <= 1'b0;
      rd_addr    <= '0;
    end else begin
      if (cfg_wen) begin
        capacity <= cfg_wdata;
      end
      unique case (state)
        S_IDLE: begin
          if (acc) begin
            if (action == blsb_pkg::ACT_PUSH) begin
              burst_left <= new_burst ? blsb_pkg::CNT_W'(n - 1'b1)
                                      : blsb_pkg::CNT_W'(burst_left - 1'b1);
              burst_rej  <= rej;
              fill       <= fill_after;
            end else if (action != blsb_pkg::ACT_NONE) begin
              burst_left <= '0;
              burst_rej  <= 1'b0;
              fill       <= fill_after;
              if (!cnt_zero && !underflow) begin
                state     <= S_BURST;
                remaining <= count;
                rd_addr   <= base[ADDR_W-1:0];
              end
            end
          end
        end
        S_BURST: begin
          if (issue) begin
            remaining <= blsb_pkg::CNT_W'(remaining - 1'b1);
            rd_addr   <= ADDR_W'(rd_addr + 1'b1);
            pend_last <= (remaining == blsb_pkg::CNT_W'(1));
            pending   <= 1'b1;
          end else if (load_burst) begin
            pending <= 1'b0;
          end
          if ((remaining == '0) && (!pending || load_burst)) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(DEPTH))
    else $error("fill level beyond depth");

  a_no_write_in_burst: assert property (@(posedge clk) disable iff (rst)
    (state == S_BURST) |-> !ram_we)
    else $error("ram write while a read burst runs");

  a_issue_fills: assert property (@(posedge clk) disable iff (rst)
    issue |=> pending)
    else $error("issued read not marked pending");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (load_burst && pend_last) |-> (remaining == '0))
    else $error("last element sent with reads outstanding");

endmodule

// File: rtl/bounded_lifo_stack_with_bursts.sv
// top level of the bounded lifo stack with burst push, pop and peek
`timescale 1ns / 1ps
// Bounded LIFO stack held in one synchronous RAM. A push request gives one
// result; a burst is checked against free space on its first request. Pop
// and peek of zero elements and an underflow also give one result each. A pop
// or peek of n elements returns them deepest first, one per cycle while the
// output is not stalled, and holds off requests until the stream ends; the
// request sets up the read address, and the RAM read is registered ahead of
// the stream. A result waiting in the output register holds off new requests;
// a request is taken in the cycle that result leaves, and backpressure on the
// output stalls the RAM read stream without loss. Action code 3 is taken and
// ignored. The capacity register (reset 20) is written through cfg_wen and
// cfg_wdata; the user must write it while the block is idle (not enforced).
module bounded_lifo_stack_with_bursts #(
  parameter int DEPTH = blsb_pkg::DEPTH_DEFAULT,
  parameter int WIDTH = blsb_pkg::WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [5:0]  cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // count[5:0], data[37:6], zero pad [39:38]
  input  logic [1:0]  s_tuser,  // action[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // data_out[31:0], occupancy[37:32], is_empty[38], pad[39]
  output logic [1:0]  m_tuser,  // status[1:0]
  output logic        m_tlast
);

  localparam int ADDR_W = $clog2(DEPTH);

  blsb_pkg::res_t     res;
  logic               out_free;
  logic               ram_we;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [WIDTH-1:0]   ram_wdata;
  logic [WIDTH-1:0]   ram_rdata;

  logic [blsb_pkg::DATA_W-1:0] out_data;
  logic [blsb_pkg::CNT_W-1:0]  out_occ;
  logic                        out_empty;
  blsb_pkg::status_t           out_status;
  logic                        out_last;

  assign out_free = !m_tvalid || m_tready;

  blsb_ctrl #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .action    (blsb_pkg::action_t'(s_tuser)),
    .count     (s_tdata[5:0]),
    .data      (s_tdata[37:6]),
    .out_free  (out_free),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr)
  );

  blsb_ram #(
    .WIDTH (WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      out_data   <= res.from_ram ? blsb_pkg::DATA_W'(ram_rdata) : '0;
      out_occ    <= res.occupancy;
      out_empty  <= res.is_empty;
      out_status <= res.status;
      out_last   <= res.last;
    end
  end

  assign m_tdata = {1'b0, out_empty, out_occ, out_data};
  assign m_tuser = out_status;
  assign m_tlast = out_last;

endmodule
